// File: sv/assert_macros.svh
// Assertion helpers, included by the RTL file dtsi_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition leads to a consequence on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dtsi_pkg.sv
package dtsi_pkg;

    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 7;

    localparam logic [FRAC_W-1:0] FRAC_MAX   = 7'd127;
    localparam logic [CFG_W-1:0]  MAX_DIGITS = 6'd38;
    localparam logic [CFG_W-1:0]  DIGITS_W16 = 6'd4;
    localparam logic [CFG_W-1:0]  DIGITS_W32 = 6'd9;
    localparam logic [CFG_W-1:0]  DIGITS_W64 = 6'd18;
    localparam logic [CFG_W-1:0]  SCALE_RESET     = 6'd0;
    localparam logic [CFG_W-1:0]  PRECISION_RESET = 6'd18;

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE     = 2'd0,
        CFG_PRECISION = 2'd1
    } cfg_index_t;

    // Storage width codes
    typedef enum logic [1:0] {
        WIDTH_16  = 2'd0,
        WIDTH_32  = 2'd1,
        WIDTH_64  = 2'd2,
        WIDTH_128 = 2'd3
    } width_code_t;

    // Request to the result formatter
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               negate;
        logic [CFG_W-1:0]   precision;
    } fmt_req_t;

endpackage

// File: sv/dtsi_char_if.sv
interface dtsi_char_if;
    import dtsi_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_byte;
    logic              end_of_text;

    modport source (output valid, output char_byte, output end_of_text, input ready);
    modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

// File: sv/dtsi_result_if.sv
interface dtsi_result_if;
    import dtsi_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] scaled_value;
    logic [1:0]         width_code;

    modport source (output valid, output scaled_value, output width_code, input ready);
    modport sink   (input valid, input scaled_value, input width_code, output ready);
endinterface

// File: sv/dtsi_cfg_if.sv
interface dtsi_cfg_if;
    import dtsi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/decimal_text_to_scaled_int.sv
// Channel     Role    Payload
// char_in     sink    char_byte[7:0], end_of_text
// result_out  source  scaled_value[63:0] (signed), width_code[1:0]
// cfg         sink    index[1:0] (0 scale, 1 precision), data[5:0]
//
// Each character but a minus or the first dot is folded in by the shared
// multiply-by-ten adder. After the last character the same unit multiplies
// by ten max(0, scale - fraction count) more times (up to 63), then the
// result register loads. That load waits while an earlier result is not yet
// taken; no character is accepted from the last character until the load.
// Async reset clears the number state; scale resets to 0, precision to 18.
module decimal_text_to_scaled_int (
    input  logic          clk,
    input  logic          rst_n,
    dtsi_char_if.sink     char_in,
    dtsi_result_if.source result_out,
    dtsi_cfg_if.sink      cfg
);
    import dtsi_pkg::*;

    logic [VALUE_W-1:0] mac_a;
    logic [VALUE_W-1:0] mac_addend;
    logic [VALUE_W-1:0] mac_y;
    fmt_req_t           fmt_req;
    logic [VALUE_W-1:0] fmt_value;
    width_code_t        fmt_code;

    dtsi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .result_out (result_out),
        .cfg        (cfg),
        .mac_a      (mac_a),
        .mac_addend (mac_addend),
        .mac_y      (mac_y),
        .fmt_req    (fmt_req),
        .fmt_value  (fmt_value),
        .fmt_code   (fmt_code)
    );

    dtsi_mac10 u_mac10 (
        .a      (mac_a),
        .addend (mac_addend),
        .y      (mac_y)
    );

    dtsi_fmt u_fmt (
        .req   (fmt_req),
        .value (fmt_value),
        .code  (fmt_code)
    );
endmodule

// File: sv/dtsi_mac10.sv
module dtsi_mac10 (
    input  logic [dtsi_pkg::VALUE_W-1:0] a,
    input  logic [dtsi_pkg::VALUE_W-1:0] addend,
    output logic [dtsi_pkg::VALUE_W-1:0] y
);
    import dtsi_pkg::*;

    // Multiply by ten as 8a + 2a, then add, wrapping at the word width
    assign y = (a << 3) + (a << 1) + addend;
endmodule

// File: sv/dtsi_fmt.sv
module dtsi_fmt (
    input  dtsi_pkg::fmt_req_t            req,
    output logic [dtsi_pkg::VALUE_W-1:0]  value,
    output dtsi_pkg::width_code_t         code
);
    import dtsi_pkg::*;

    logic [VALUE_W-1:0] signed_v;
    logic [CFG_W-1:0]   prec;

    // Apply the sign; negation commutes with the scaling by ten
    assign signed_v = req.negate ? (VALUE_W'(0) - req.value) : req.value;
    assign prec     = (req.precision > MAX_DIGITS) ? MAX_DIGITS : req.precision;

    // Pick storage width; for 16 and 32 bits truncate and sign-extend
    always_comb
    begin
        if (prec <= DIGITS_W16)
        begin
            code  = WIDTH_16;
            value = {{(VALUE_W-16){signed_v[15]}}, signed_v[15:0]};
        end
        else if (prec <= DIGITS_W32)
        begin
            code  = WIDTH_32;
            value = {{(VALUE_W-32){signed_v[31]}}, signed_v[31:0]};
        end
        else if (prec <= DIGITS_W64)
        begin
            code  = WIDTH_64;
            value = signed_v;
        end
        else
        begin
            code  = WIDTH_128;
            value = signed_v;
        end
    end
endmodule

// File: sv/dtsi_ctrl.sv
module dtsi_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    dtsi_char_if.sink                     char_in,
    dtsi_result_if.source                 result_out,
    dtsi_cfg_if.sink                      cfg,
    output logic [dtsi_pkg::VALUE_W-1:0]  mac_a,
    output logic [dtsi_pkg::VALUE_W-1:0]  mac_addend,
    input  logic [dtsi_pkg::VALUE_W-1:0]  mac_y,
    output dtsi_pkg::fmt_req_t            fmt_req,
    input  logic [dtsi_pkg::VALUE_W-1:0]  fmt_value,
    input  dtsi_pkg::width_code_t         fmt_code
);
    import dtsi_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_ACC,
        S_SCALE,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               at_start_reg, at_start_next;
    logic               minus_reg, minus_next;
    logic               dot_reg, dot_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [CFG_W-1:0]   cnt_reg, cnt_next;
    logic [CFG_W-1:0]   scale_reg, scale_next;
    logic [CFG_W-1:0]   precision_reg, precision_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    width_code_t        out_code_reg, out_code_next;

    logic              accept;
    logic              is_minus;
    logic              first_dot;
    logic              fold;
    logic [FRAC_W-1:0] frac_acc;
    logic              load;

    // Character decode
    assign char_in.ready = (state_reg == S_ACC);
    assign accept    = char_in.valid && char_in.ready;
    assign is_minus  = (char_in.char_byte == CHAR_MINUS);
    assign first_dot = (char_in.char_byte == CHAR_DOT) && !dot_reg;
    assign fold      = !first_dot && !is_minus;
    assign frac_acc  = (!first_dot && dot_reg && frac_reg != FRAC_MAX)
                       ? frac_reg + FRAC_W'(1) : frac_reg;

    // Shared unit operands: fold a digit while accumulating, scale otherwise
    assign mac_a      = acc_reg;
    assign mac_addend = (state_reg == S_ACC)
                        ? ({{(VALUE_W-BYTE_W){1'b0}}, char_in.char_byte}
                           - {{(VALUE_W-BYTE_W){1'b0}}, CHAR_ZERO})
                        : '0;

    assign fmt_req.value     = acc_reg;
    assign fmt_req.negate    = minus_reg;
    assign fmt_req.precision = precision_reg;

    assign load = (state_reg == S_DONE) && (!out_valid_reg || result_out.ready);

    assign result_out.valid        = out_valid_reg;
    assign result_out.scaled_value = out_value_reg;
    assign result_out.width_code   = out_code_reg;
    assign cfg.ready               = 1'b1;

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        at_start_next  = at_start_reg;
        minus_next     = minus_reg;
        dot_next       = dot_reg;
        frac_next      = frac_reg;
        cnt_next       = cnt_reg;
        scale_next     = scale_reg;
        precision_next = precision_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_code_next  = out_code_reg;

        // Drop the result once taken
        if (out_valid_reg && result_out.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_ACC:
            begin
                if (accept)
                begin
                    if (fold)
                        acc_next = mac_y;
                    at_start_next = 1'b0;
                    minus_next    = minus_reg || (at_start_reg && is_minus);
                    dot_next      = dot_reg || first_dot;
                    frac_next     = frac_acc;
                    if (char_in.end_of_text)
                    begin
                        if ({1'b0, scale_reg} > frac_acc)
                        begin
                            cnt_next   = scale_reg - frac_acc[CFG_W-1:0];
                            state_next = S_SCALE;
                        end
                        else
                            state_next = S_DONE;
                    end
                end
            end
            S_SCALE:
            begin
                acc_next = mac_y;
                cnt_next = cnt_reg - CFG_W'(1);
                if (cnt_reg == CFG_W'(1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = fmt_value;
                    out_code_next  = fmt_code;
                    acc_next       = '0;
                    at_start_next  = 1'b1;
                    minus_next     = 1'b0;
                    dot_next       = 1'b0;
                    frac_next      = '0;
                    state_next     = S_ACC;
                end
            end
            default:
                state_next = S_ACC;
        endcase

        // Configuration writes
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_SCALE:     scale_next     = cfg.data;
                CFG_PRECISION: precision_next = cfg.data;
                default:       ;
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            acc_reg       <= '0;
            at_start_reg  <= 1'b1;
            minus_reg     <= 1'b0;
            dot_reg       <= 1'b0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            scale_reg     <= SCALE_RESET;
            precision_reg <= PRECISION_RESET;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_code_reg  <= WIDTH_16;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            at_start_reg  <= at_start_next;
            minus_reg     <= minus_next;
            dot_reg       <= dot_next;
            frac_reg      <= frac_next;
            cnt_reg       <= cnt_next;
            scale_reg     <= scale_next;
            precision_reg <= precision_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_code_reg  <= out_code_next;
        end
    end

    `ASSERT_CLK(a_scale_cnt_live, clk, rst_n, (state_reg != S_SCALE) || (cnt_reg != '0), "scaling with zero count")
    `ASSERT_NEXT(a_scale_cnt_step, clk, rst_n, (state_reg == S_SCALE) && (cnt_reg > CFG_W'(1)), (state_reg == S_SCALE) && (cnt_reg == $past(cnt_reg) - CFG_W'(1)), "scale count skipped")
    `ASSERT_NEXT(a_clear_after_load, clk, rst_n, load, (acc_reg == '0) && at_start_reg && !dot_reg && out_valid_reg, "number state not cleared after result")
endmodule
